// ===== design/cpps_pkg.sv =====
// Shared types, constants and helpers of the particle physics step block.
`default_nettype none
package cpps_pkg;

  typedef enum logic [2:0] {
    CFG_EN_GRAVITY    = 3'd0,
    CFG_EN_COLLISIONS = 3'd1,
    CFG_EN_WALLS      = 3'd2,
    CFG_COUNT         = 3'd3,
    CFG_GRAVITY       = 3'd4,
    CFG_RADIUS        = 3'd5,
    CFG_WIDTH         = 3'd6,
    CFG_HEIGHT        = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_STEP  = 2'd1,
    FN_READ  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  localparam logic        RST_EN_GRAVITY    = 1'b0;
  localparam logic        RST_EN_COLLISIONS = 1'b0;
  localparam logic        RST_EN_WALLS      = 1'b1;
  localparam logic [8:0]  RST_COUNT         = 9'd0;
  localparam logic [31:0] RST_GRAVITY       = 32'd64290816;
  localparam logic [30:0] RST_RADIUS        = 31'd327680;
  localparam logic [30:0] RST_WIDTH         = 31'd83886080;
  localparam logic [30:0] RST_HEIGHT        = 31'd47185920;

  localparam logic signed [32:0] BOUNCE_Q16 = -33'sd45875;

  typedef enum logic [3:0] {
    M_NONE, M_R2, M_G, M_VX, M_VY, M_SQX, M_SQY, M_PX, M_PY, M_BX, M_BY
  } mul_sel_t;

  typedef enum logic [3:0] {
    U_NONE, U_VY_G, U_PX, U_PY, U_VX_B, U_VY_B, U_CLAMP, U_APPLY
  } upd_t;

  typedef enum logic [1:0] {
    RS_IDX, RS_I, RS_J
  } rd_src_t;

  typedef struct packed {
    logic     accept;
    logic     wr_in;
    logic     wr_a;
    logic     wr_b;
    logic     rd_en;
    rd_src_t  rd_src;
    logic     ld_a;
    logic     ld_b;
    logic     out_rd;
    logic     step_init;
    logic     save_r2;
    logic     i_clr;
    logic     i_inc;
    logic     j_set;
    logic     j_inc;
    logic     sqx_save;
    logic     s_sum;
    logic     sq_start;
    logic     sq_step;
    logic     pen;
    logic     div_start;
    logic     div_step;
    logic     mx_save;
    logic     mul_en;
    mul_sel_t mul_sel;
    upd_t     upd;
  } dp_cmd_t;

  typedef struct packed {
    logic i_done;
    logic j_done;
    logic rd_fixed;
    logic near;
    logic s_ok;
    logic sq_done;
    logic dv_done;
    logic bx_pend;
    logic by_pend;
    logic en_grav;
    logic en_coll;
    logic en_walls;
  } dp_status_t;

  function automatic logic signed [63:0] sx64(input logic [31:0] v);
    sx64 = $signed({{32{v[31]}}, v});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      sat32 = -32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/cpps_ctrl.sv =====
// Sequencer that steps the datapath through write, read and physics step items.
`default_nettype none
module cpps_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire [1:0]             in_func,
  input  cpps_pkg::dp_status_t  status,
  output logic                  busy,
  output cpps_pkg::dp_cmd_t     cmd
);

  typedef enum logic [41:0] {
    S_IDLE    = 42'd1 << 0,  S_WR      = 42'd1 << 1,  S_RD_A    = 42'd1 << 2,
    S_RD_B    = 42'd1 << 3,  S_ST_INIT = 42'd1 << 4,  S_ST_R2   = 42'd1 << 5,
    S_G_CHK   = 42'd1 << 6,  S_G_LD    = 42'd1 << 7,  S_G_MG    = 42'd1 << 8,
    S_G_AG    = 42'd1 << 9,  S_G_MX    = 42'd1 << 10, S_G_AX    = 42'd1 << 11,
    S_G_MY    = 42'd1 << 12, S_G_AY    = 42'd1 << 13, S_G_WR    = 42'd1 << 14,
    S_C_ICHK  = 42'd1 << 15, S_C_JCHK  = 42'd1 << 16, S_C_LDI   = 42'd1 << 17,
    S_C_LDJ   = 42'd1 << 18, S_C_CHK   = 42'd1 << 19, S_C_SQY   = 42'd1 << 20,
    S_C_SQS   = 42'd1 << 21, S_C_SCHK  = 42'd1 << 22, S_C_SQRT  = 42'd1 << 23,
    S_C_PEN   = 42'd1 << 24, S_C_MX    = 42'd1 << 25, S_C_DXS   = 42'd1 << 26,
    S_C_DX    = 42'd1 << 27, S_C_MY    = 42'd1 << 28, S_C_DYS   = 42'd1 << 29,
    S_C_DY    = 42'd1 << 30, S_C_APPLY = 42'd1 << 31, S_C_WRI   = 42'd1 << 32,
    S_C_WRJ   = 42'd1 << 33, S_W_CHK   = 42'd1 << 34, S_W_LD    = 42'd1 << 35,
    S_W_CL    = 42'd1 << 36, S_W_BX    = 42'd1 << 37, S_W_BXA   = 42'd1 << 38,
    S_W_BY    = 42'd1 << 39, S_W_BYA   = 42'd1 << 40, S_W_WR    = 42'd1 << 41
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (cpps_pkg::func_t'(in_func))
            cpps_pkg::FN_WRITE: state_nxt = S_WR;
            cpps_pkg::FN_STEP:  state_nxt = S_ST_INIT;
            cpps_pkg::FN_READ:  state_nxt = S_RD_A;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_WR: begin
        cmd.wr_in = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = cpps_pkg::RS_IDX;
        state_nxt  = S_RD_B;
      end
      S_RD_B: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_ST_INIT: begin
        cmd.step_init = 1'b1;
        cmd.i_clr     = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = cpps_pkg::M_R2;
        state_nxt     = S_ST_R2;
      end
      S_ST_R2: begin
        cmd.save_r2 = 1'b1;
        state_nxt   = S_G_CHK;
      end
      S_G_CHK: begin
        if (status.i_done) begin
          cmd.i_clr = 1'b1;
          state_nxt = S_C_ICHK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = cpps_pkg::RS_I;
          state_nxt  = S_G_LD;
        end
      end
      S_G_LD: begin
        cmd.ld_a = 1'b1;
        if (status.rd_fixed) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_G_CHK;
        end else if (status.en_grav) begin
          state_nxt = S_G_MG;
        end else begin
          state_nxt = S_G_MX;
        end
      end
      S_G_MG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpps_pkg::M_G;
        state_nxt   = S_G_AG;
      end
      S_G_AG: begin
        cmd.upd   = cpps_pkg::U_VY_G;
        state_nxt = S_G_MX;
      end
      S_G_MX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpps_pkg::M_VX;
        state_nxt   = S_G_AX;
      end
      S_G_AX: begin
        cmd.upd   = cpps_pkg::U_PX;
        state_nxt = S_G_MY;
      end
      S_G_MY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpps_pkg::M_VY;
        state_nxt   = S_G_AY;
      end
      S_G_AY: begin
        cmd.upd   = cpps_pkg::U_PY;
        state_nxt = S_G_WR;
      end
      S_G_WR: begin
        cmd.wr_a  = 1'b1;
        cmd.i_inc = 1'b1;
        state_nxt = S_G_CHK;
      end
      S_C_ICHK: begin
        if (!status.en_coll || status.i_done) begin
          cmd.i_clr = 1'b1;
          state_nxt = S_W_CHK;
        end else begin
          cmd.j_set = 1'b1;
          state_nxt = S_C_JCHK;
        end
      end
      S_C_JCHK: begin
        if (status.j_done) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_C_ICHK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = cpps_pkg::RS_I;
          state_nxt  = S_C_LDI;
        end
      end
      S_C_LDI: begin
        cmd.ld_a   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_src = cpps_pkg::RS_J;
        state_nxt  = S_C_LDJ;
      end
      S_C_LDJ: begin
        cmd.ld_b  = 1'b1;
        state_nxt = S_C_CHK;
      end
      S_C_CHK: begin
        if (status.near) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = cpps_pkg::M_SQX;
          state_nxt   = S_C_SQY;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_C_JCHK;
        end
      end
      S_C_SQY: begin
        cmd.sqx_save = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = cpps_pkg::M_SQY;
        state_nxt    = S_C_SQS;
      end
      S_C_SQS: begin
        cmd.s_sum = 1'b1;
        state_nxt = S_C_SCHK;
      end
      S_C_SCHK: begin
        if (status.s_ok) begin
          cmd.sq_start = 1'b1;
          state_nxt    = S_C_SQRT;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_C_JCHK;
        end
      end
      S_C_SQRT: begin
        if (status.sq_done) begin
          state_nxt = S_C_PEN;
        end else begin
          cmd.sq_step = 1'b1;
        end
      end
      S_C_PEN: begin
        cmd.pen   = 1'b1;
        state_nxt = S_C_MX;
      end
      S_C_MX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpps_pkg::M_PX;
        state_nxt   = S_C_DXS;
      end
      S_C_DXS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_C_DX;
      end
      S_C_DX: begin
        if (status.dv_done) begin
          state_nxt = S_C_MY;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_C_MY: begin
        cmd.mx_save = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpps_pkg::M_PY;
        state_nxt   = S_C_DYS;
      end
      S_C_DYS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_C_DY;
      end
      S_C_DY: begin
        if (status.dv_done) begin
          state_nxt = S_C_APPLY;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_C_APPLY: begin
        cmd.upd   = cpps_pkg::U_APPLY;
        state_nxt = S_C_WRI;
      end
      S_C_WRI: begin
        cmd.wr_a  = 1'b1;
        state_nxt = S_C_WRJ;
      end
      S_C_WRJ: begin
        cmd.wr_b  = 1'b1;
        cmd.j_inc = 1'b1;
        state_nxt = S_C_JCHK;
      end
      S_W_CHK: begin
        if (!status.en_walls || status.i_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = cpps_pkg::RS_I;
          state_nxt  = S_W_LD;
        end
      end
      S_W_LD: begin
        cmd.ld_a = 1'b1;
        if (status.rd_fixed) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_W_CHK;
        end else begin
          state_nxt = S_W_CL;
        end
      end
      S_W_CL: begin
        cmd.upd   = cpps_pkg::U_CLAMP;
        state_nxt = S_W_BX;
      end
      S_W_BX: begin
        if (status.bx_pend) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = cpps_pkg::M_BX;
          state_nxt   = S_W_BXA;
        end else begin
          state_nxt = S_W_BY;
        end
      end
      S_W_BXA: begin
        cmd.upd   = cpps_pkg::U_VX_B;
        state_nxt = S_W_BX;
      end
      S_W_BY: begin
        if (status.by_pend) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = cpps_pkg::M_BY;
          state_nxt   = S_W_BYA;
        end else begin
          state_nxt = S_W_WR;
        end
      end
      S_W_BYA: begin
        cmd.upd   = cpps_pkg::U_VY_B;
        state_nxt = S_W_BY;
      end
      S_W_WR: begin
        cmd.wr_a  = 1'b1;
        cmd.i_inc = 1'b1;
        state_nxt = S_W_CHK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/cpps_dp.sv =====
// Datapath: particle store, config registers, shared multiplier, square root and divider.
`default_nettype none
module cpps_dp #(
  parameter int MAX_PARTICLES = 256
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire [1:0]             in_func,
  input  wire [7:0]             in_index,
  input  wire signed [31:0]     in_pos_x,
  input  wire signed [31:0]     in_pos_y,
  input  wire signed [31:0]     in_vel_x,
  input  wire signed [31:0]     in_vel_y,
  input  wire                   in_fixed,
  input  wire [15:0]            in_time_step,
  input  wire                   cfg_valid,
  input  wire [2:0]             cfg_index,
  input  wire [31:0]            cfg_data,
  input  cpps_pkg::dp_cmd_t     cmd,
  output cpps_pkg::dp_status_t  status,
  output logic                  out_valid,
  output logic signed [31:0]    out_pos_x,
  output logic signed [31:0]    out_pos_y,
  output logic signed [31:0]    out_vel_x,
  output logic signed [31:0]    out_vel_y,
  output logic                  out_fixed
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        fixed;
  } part_t;

  logic        en_grav_r, en_coll_r, en_walls_r;
  logic [8:0]  count_r;
  logic [31:0] grav_r;
  logic [30:0] radius_r, width_r, height_r;

  logic [7:0]  idx_r;
  part_t       inp_r;
  logic [15:0] dt_r;
  logic        idx_ok;

  part_t       mem [MAX_PARTICLES];
  part_t       rdata_r;
  logic [AW-1:0] rd_addr, wr_addr;
  part_t       wr_data;
  logic        wr_en;

  logic [CW-1:0] n_r, i_r, j_r;
  part_t       a_r, b_r;
  logic        sx_r, sy_r;
  logic [32:0] adx_r, ady_r;
  logic signed [32:0] dx_c, dy_c;

  logic [31:0] two_r;
  logic [63:0] r2_r, sqx_r;
  logic [64:0] s_r;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_r;
  logic signed [63:0] psh;

  logic [63:0] sq_rem_r, sq_res_r, sq_bit_r, sq_trial;
  logic [5:0]  sq_cnt_r;
  logic [31:0] dist_r, pen_r;
  logic [63:0] dq_r;
  logic [32:0] drem_r, dvs;
  logic [33:0] dv_t;
  logic        dv_ge;
  logic [6:0]  dv_cnt_r;
  logic [31:0] mx_r;
  logic [1:0]  bx_cnt_r, by_cnt_r;

  logic signed [63:0] rr, ww, hh, xs, ys, x1, y1, x2, y2, cx, cy;
  logic lx, rx, ly, ry;

  logic        out_valid_r;
  part_t       out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_grav_r  <= cpps_pkg::RST_EN_GRAVITY;
      en_coll_r  <= cpps_pkg::RST_EN_COLLISIONS;
      en_walls_r <= cpps_pkg::RST_EN_WALLS;
      count_r    <= cpps_pkg::RST_COUNT;
      grav_r     <= cpps_pkg::RST_GRAVITY;
      radius_r   <= cpps_pkg::RST_RADIUS;
      width_r    <= cpps_pkg::RST_WIDTH;
      height_r   <= cpps_pkg::RST_HEIGHT;
    end else if (cfg_valid) begin
      case (cpps_pkg::cfg_idx_t'(cfg_index))
        cpps_pkg::CFG_EN_GRAVITY:    en_grav_r  <= cfg_data[0];
        cpps_pkg::CFG_EN_COLLISIONS: en_coll_r  <= cfg_data[0];
        cpps_pkg::CFG_EN_WALLS:      en_walls_r <= cfg_data[0];
        cpps_pkg::CFG_COUNT:         count_r    <= cfg_data[8:0];
        cpps_pkg::CFG_GRAVITY:       grav_r     <= cfg_data;
        cpps_pkg::CFG_RADIUS:        radius_r   <= cfg_data[30:0];
        cpps_pkg::CFG_WIDTH:         width_r    <= cfg_data[30:0];
        cpps_pkg::CFG_HEIGHT:        height_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // input item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= in_index;
      inp_r <= '{px: in_pos_x, py: in_pos_y, vx: in_vel_x, vy: in_vel_y, fixed: in_fixed};
      dt_r  <= in_time_step;
    end
  end

  assign idx_ok = ({24'd0, idx_r} < 32'(MAX_PARTICLES));

  // particle store
  always_comb begin
    case (cmd.rd_src)
      cpps_pkg::RS_IDX: rd_addr = AW'(idx_r);
      cpps_pkg::RS_I:   rd_addr = i_r[AW-1:0];
      cpps_pkg::RS_J:   rd_addr = j_r[AW-1:0];
      default:          rd_addr = AW'(idx_r);
    endcase
    if (cmd.wr_b) begin
      wr_addr = j_r[AW-1:0];
      wr_data = b_r;
      wr_en   = !b_r.fixed;
    end else if (cmd.wr_a) begin
      wr_addr = i_r[AW-1:0];
      wr_data = a_r;
      wr_en   = !a_r.fixed;
    end else begin
      wr_addr = AW'(idx_r);
      wr_data = inp_r;
      wr_en   = cmd.wr_in && idx_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
      i_r <= '0;
      j_r <= '0;
    end else begin
      if (cmd.step_init) begin
        n_r <= ({23'd0, count_r} > 32'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES) : CW'(count_r);
      end
      if (cmd.i_clr) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + CW'(1);
      end
      if (cmd.j_set) begin
        j_r <= i_r + CW'(1);
      end else if (cmd.j_inc) begin
        j_r <= j_r + CW'(1);
      end
    end
  end

  assign two_r = {radius_r, 1'b0};
  assign dx_c  = $signed({rdata_r.px[31], rdata_r.px}) - $signed({a_r.px[31], a_r.px});
  assign dy_c  = $signed({rdata_r.py[31], rdata_r.py}) - $signed({a_r.py[31], a_r.py});

  // shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      cpps_pkg::M_R2:  begin ma = {1'b0, two_r};          mb = {1'b0, two_r};          end
      cpps_pkg::M_G:   begin ma = {grav_r[31], grav_r};   mb = {17'd0, dt_r};          end
      cpps_pkg::M_VX:  begin ma = {a_r.vx[31], a_r.vx};   mb = {17'd0, dt_r};          end
      cpps_pkg::M_VY:  begin ma = {a_r.vy[31], a_r.vy};   mb = {17'd0, dt_r};          end
      cpps_pkg::M_SQX: begin ma = {1'b0, adx_r[31:0]};    mb = {1'b0, adx_r[31:0]};    end
      cpps_pkg::M_SQY: begin ma = {1'b0, ady_r[31:0]};    mb = {1'b0, ady_r[31:0]};    end
      cpps_pkg::M_PX:  begin ma = {1'b0, adx_r[31:0]};    mb = {1'b0, pen_r};          end
      cpps_pkg::M_PY:  begin ma = {1'b0, ady_r[31:0]};    mb = {1'b0, pen_r};          end
      cpps_pkg::M_BX:  begin ma = {a_r.vx[31], a_r.vx};   mb = cpps_pkg::BOUNCE_Q16;   end
      cpps_pkg::M_BY:  begin ma = {a_r.vy[31], a_r.vy};   mb = cpps_pkg::BOUNCE_Q16;   end
      default:         begin ma = '0;                     mb = '0;                     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= ma * mb;
    end
  end

  assign psh = 64'(prod_r >>> 16);

  // wall clamp terms
  always_comb begin
    rr = $signed({33'd0, radius_r});
    ww = $signed({33'd0, width_r});
    hh = $signed({33'd0, height_r});
    xs = cpps_pkg::sx64(a_r.px);
    ys = cpps_pkg::sx64(a_r.py);
    lx = (xs - rr) < 0;
    x1 = lx ? rr : xs;
    rx = (x1 + rr) > ww;
    x2 = rx ? (ww - rr) : x1;
    ly = (ys - rr) < 0;
    y1 = ly ? rr : ys;
    ry = (y1 + rr) > hh;
    y2 = ry ? (hh - rr) : y1;
    cx = sx_r ? -$signed({32'd0, mx_r}) : $signed({32'd0, mx_r});
    cy = sy_r ? -$signed({32'd0, dq_r[31:0]}) : $signed({32'd0, dq_r[31:0]});
  end

  // working particle registers
  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      a_r <= rdata_r;
    end
    if (cmd.ld_b) begin
      b_r   <= rdata_r;
      sx_r  <= dx_c[32];
      sy_r  <= dy_c[32];
      adx_r <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
      ady_r <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
    end
    case (cmd.upd)
      cpps_pkg::U_VY_G: a_r.vy <= cpps_pkg::sat32(cpps_pkg::sx64(a_r.vy) + psh);
      cpps_pkg::U_PX:   a_r.px <= cpps_pkg::sat32(cpps_pkg::sx64(a_r.px) + psh);
      cpps_pkg::U_PY:   a_r.py <= cpps_pkg::sat32(cpps_pkg::sx64(a_r.py) + psh);
      cpps_pkg::U_VX_B: a_r.vx <= cpps_pkg::sat32(psh);
      cpps_pkg::U_VY_B: a_r.vy <= cpps_pkg::sat32(psh);
      cpps_pkg::U_CLAMP: begin
        a_r.px <= cpps_pkg::sat32(x2);
        a_r.py <= cpps_pkg::sat32(y2);
      end
      cpps_pkg::U_APPLY: begin
        a_r.px <= cpps_pkg::sat32(cpps_pkg::sx64(a_r.px) - cx);
        a_r.py <= cpps_pkg::sat32(cpps_pkg::sx64(a_r.py) - cy);
        b_r.px <= cpps_pkg::sat32(cpps_pkg::sx64(b_r.px) + cx);
        b_r.py <= cpps_pkg::sat32(cpps_pkg::sx64(b_r.py) + cy);
      end
      default: ;
    endcase
  end

  // bounce counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_cnt_r <= '0;
      by_cnt_r <= '0;
    end else if (cmd.upd == cpps_pkg::U_CLAMP) begin
      bx_cnt_r <= {1'b0, lx} + {1'b0, rx};
      by_cnt_r <= {1'b0, ly} + {1'b0, ry};
    end else if (cmd.mul_en && cmd.mul_sel == cpps_pkg::M_BX) begin
      bx_cnt_r <= bx_cnt_r - 2'd1;
    end else if (cmd.mul_en && cmd.mul_sel == cpps_pkg::M_BY) begin
      by_cnt_r <= by_cnt_r - 2'd1;
    end
  end

  // squared distance
  always_ff @(posedge clk) begin
    if (cmd.save_r2) begin
      r2_r <= prod_r[63:0];
    end
    if (cmd.sqx_save) begin
      sqx_r <= prod_r[63:0];
    end
    if (cmd.s_sum) begin
      s_r <= {1'b0, sqx_r} + {1'b0, prod_r[63:0]};
    end
  end

  // square root, one result bit per cycle
  assign sq_trial = sq_res_r + sq_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
    end else if (cmd.sq_start) begin
      sq_cnt_r <= 6'd32;
    end else if (cmd.sq_step && sq_cnt_r != '0) begin
      sq_cnt_r <= sq_cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      sq_rem_r <= s_r[63:0];
      sq_res_r <= '0;
      sq_bit_r <= 64'd1 << 62;
    end else if (cmd.sq_step) begin
      if (sq_rem_r >= sq_trial) begin
        sq_rem_r <= sq_rem_r - sq_trial;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.pen) begin
      dist_r <= sq_res_r[31:0];
      pen_r  <= two_r - sq_res_r[31:0];
    end
  end

  // restoring divider, one quotient bit per cycle
  assign dvs   = {dist_r, 1'b0};
  assign dv_t  = {drem_r, dq_r[63]};
  assign dv_ge = (dv_t >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_cnt_r <= '0;
    end else if (cmd.div_start) begin
      dv_cnt_r <= 7'd64;
    end else if (cmd.div_step && dv_cnt_r != '0) begin
      dv_cnt_r <= dv_cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq_r   <= prod_r[63:0];
      drem_r <= '0;
    end else if (cmd.div_step) begin
      drem_r <= dv_ge ? 33'(dv_t - {1'b0, dvs}) : dv_t[32:0];
      dq_r   <= {dq_r[62:0], dv_ge};
    end
    if (cmd.mx_save) begin
      mx_r <= dq_r[31:0];
    end
  end

  // read result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_rd) begin
      out_r <= idx_ok ? rdata_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = out_r.px;
  assign out_pos_y = out_r.py;
  assign out_vel_x = out_r.vx;
  assign out_vel_y = out_r.vy;
  assign out_fixed = out_r.fixed;

  assign status.i_done   = (i_r >= n_r);
  assign status.j_done   = (j_r >= n_r);
  assign status.rd_fixed = rdata_r.fixed;
  assign status.near     = (adx_r < {1'b0, two_r}) && (ady_r < {1'b0, two_r});
  assign status.s_ok     = (s_r != '0) && (s_r < {1'b0, r2_r});
  assign status.sq_done  = (sq_cnt_r == '0);
  assign status.dv_done  = (dv_cnt_r == '0);
  assign status.bx_pend  = (bx_cnt_r != '0);
  assign status.by_pend  = (by_cnt_r != '0);
  assign status.en_grav  = en_grav_r;
  assign status.en_coll  = en_coll_r;
  assign status.en_walls = en_walls_r;

  // in_func is decoded by the sequencer; a latched copy is kept here for the read-item assertion
  logic [1:0] func_r;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
    end
  end

  a_no_back_to_back_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("read result strobed twice in a row");

  a_sqrt_step_guard: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sq_step |-> sq_cnt_r != '0) else $error("square root stepped past its last bit");

  a_div_step_guard: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> dv_cnt_r != '0) else $error("divider stepped past its last bit");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_in && (cmd.wr_a || cmd.wr_b)) && !(cmd.wr_a && cmd.wr_b))
    else $error("two store writes in one cycle");

  a_read_item_func: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_rd |-> func_r == cpps_pkg::FN_READ) else $error("read result for a non-read item");

endmodule
`default_nettype wire

// ===== design/circle_particle_physics_step_top.sv =====
// Top level of the particle store and physics step block.
//
// An item is taken at a clock edge with start high and busy low. The read result
// shows on out_valid for one cycle right after busy falls and cannot be held off.
// A step item runs an integration pass over the moving particles (adding gravity
// when enabled), a collision pass over every particle pair when collisions are
// enabled and a wall pass over the moving particles when walls are enabled; fixed
// particles are skipped in the integration and wall passes. Pairs that do not touch
// are dropped after a distance check; an overlapping pair runs the square root and
// two divides, all on single shared units, and every pass reads the particle store
// one entry at a time through its single read port. Configuration is written at any
// cycle with cfg_valid high (cfg_ready is always high), between items.
`default_nettype none
module circle_particle_physics_step_top #(
  parameter int MAX_PARTICLES = 256
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire [1:0]          in_func,
  input  wire [7:0]          in_index,
  input  wire signed [31:0]  in_pos_x,
  input  wire signed [31:0]  in_pos_y,
  input  wire signed [31:0]  in_vel_x,
  input  wire signed [31:0]  in_vel_y,
  input  wire                in_fixed,
  input  wire [15:0]         in_time_step,
  output logic               out_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic               out_fixed,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [2:0]          cfg_index,
  input  wire [31:0]         cfg_data
);

  cpps_pkg::dp_cmd_t    cmd;
  cpps_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  cpps_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  cpps_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_func      (in_func),
    .in_index     (in_index),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_vel_x     (in_vel_x),
    .in_vel_y     (in_vel_y),
    .in_fixed     (in_fixed),
    .in_time_step (in_time_step),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_vel_x    (out_vel_x),
    .out_vel_y    (out_vel_y),
    .out_fixed    (out_fixed)
  );

endmodule
`default_nettype wire

// ===== verif/circle_particle_physics_step_top_tb.sv =====
// Self-checking testbench for the particle store and physics step block.
`default_nettype none
module circle_particle_physics_step_top_tb;

  typedef struct {
    cpps_pkg::func_t func;
    logic [7:0]  index;
    logic [31:0] px, py, vx, vy;
    logic        fixed;
    logic [15:0] dt;
  } item_t;

  typedef struct {
    logic [31:0] px, py, vx, vy;
    logic        fixed;
  } pview_t;

  localparam int NP = 256;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [7:0] in_index = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic in_fixed = 1'b0;
  logic [15:0] in_time_step = '0;
  logic out_valid;
  logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;
  logic out_fixed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  circle_particle_physics_step_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_index(in_index), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_fixed(in_fixed),
    .in_time_step(in_time_step), .out_valid(out_valid), .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y), .out_vel_x(out_vel_x), .out_vel_y(out_vel_y),
    .out_fixed(out_fixed), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // physics state mirror
  logic        m_grav, m_coll, m_walls;
  logic [8:0]  m_count;
  logic signed [31:0] m_gacc;
  logic [30:0] m_rad, m_wid, m_hgt;
  logic signed [31:0] s_px [NP];
  logic signed [31:0] s_py [NP];
  logic signed [31:0] s_vx [NP];
  logic signed [31:0] s_vy [NP];
  logic s_fx [NP];

  item_t  pending_items[$];
  pview_t read_results[$];
  int     errors = 0;
  int     hold_dense = 0;
  bit     stim_done = 0;
  bit     cfg_req = 0;
  logic [2:0]  cfg_req_idx;
  logic [31:0] cfg_req_data;

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] scale_dt(input logic signed [31:0] v,
                                                  input logic [15:0] dt);
    logic signed [63:0] p;
    p = 64'(v) * $signed({48'd0, dt});
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] rebound(input logic signed [31:0] v);
    logic signed [63:0] p;
    p = 64'(v) * -64'sd45875;
    return clip32(p >>> 16);
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] s);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic separate_pair(input int i, input int j);
    logic signed [63:0] dx, dy, cx, cy;
    logic [63:0] two_r, adx, ady, s1, s, dst, pen, mx, my;
    dx = 64'(s_px[j]) - 64'(s_px[i]);
    dy = 64'(s_py[j]) - 64'(s_py[i]);
    two_r = 64'(m_rad) * 2;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    if (adx >= two_r || ady >= two_r) return;
    s1 = adx * adx;
    s = s1 + ady * ady;
    if (s < s1) return;
    if (s == 0 || s >= two_r * two_r) return;
    dst = root64(s);
    if (dst == 0) return;
    pen = two_r - dst;
    mx = adx * pen / (2 * dst);
    my = ady * pen / (2 * dst);
    cx = dx < 0 ? -$signed(mx) : $signed(mx);
    cy = dy < 0 ? -$signed(my) : $signed(my);
    if (!s_fx[i]) begin
      s_px[i] = clip32(64'(s_px[i]) - cx);
      s_py[i] = clip32(64'(s_py[i]) - cy);
    end
    if (!s_fx[j]) begin
      s_px[j] = clip32(64'(s_px[j]) + cx);
      s_py[j] = clip32(64'(s_py[j]) + cy);
    end
  endtask

  task automatic keep_in_box(input int i);
    logic signed [63:0] r, w, h, x, y;
    r = 64'(m_rad);
    w = 64'(m_wid);
    h = 64'(m_hgt);
    x = 64'(s_px[i]);
    y = 64'(s_py[i]);
    if (x - r < 0) begin
      x = r;
      s_vx[i] = rebound(s_vx[i]);
    end
    if (x + r > w) begin
      x = w - r;
      s_vx[i] = rebound(s_vx[i]);
    end
    if (y - r < 0) begin
      y = r;
      s_vy[i] = rebound(s_vy[i]);
    end
    if (y + r > h) begin
      y = h - r;
      s_vy[i] = rebound(s_vy[i]);
    end
    s_px[i] = clip32(x);
    s_py[i] = clip32(y);
  endtask

  task automatic advance_world(input logic [15:0] dt);
    int n;
    n = m_count > NP ? NP : int'(m_count);
    for (int i = 0; i < n; i++) begin
      if (s_fx[i]) continue;
      if (m_grav) s_vy[i] = clip32(64'(s_vy[i]) + scale_dt(m_gacc, dt));
      s_px[i] = clip32(64'(s_px[i]) + scale_dt(s_vx[i], dt));
      s_py[i] = clip32(64'(s_py[i]) + scale_dt(s_vy[i], dt));
    end
    if (m_coll)
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++) separate_pair(i, j);
    if (m_walls)
      for (int i = 0; i < n; i++)
        if (!s_fx[i]) keep_in_box(i);
  endtask

  task automatic apply_item(input item_t it);
    pview_t r;
    case (it.func)
      cpps_pkg::FN_WRITE: begin
        s_px[it.index] = it.px;
        s_py[it.index] = it.py;
        s_vx[it.index] = it.vx;
        s_vy[it.index] = it.vy;
        s_fx[it.index] = it.fixed;
      end
      cpps_pkg::FN_STEP: advance_world(it.dt);
      cpps_pkg::FN_READ: begin
        r.px = s_px[it.index];
        r.py = s_py[it.index];
        r.vx = s_vx[it.index];
        r.vy = s_vy[it.index];
        r.fixed = s_fx[it.index];
        read_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [2:0] idx, input logic [31:0] d);
    case (cpps_pkg::cfg_idx_t'(idx))
      cpps_pkg::CFG_EN_GRAVITY:    m_grav = d[0];
      cpps_pkg::CFG_EN_COLLISIONS: m_coll = d[0];
      cpps_pkg::CFG_EN_WALLS:      m_walls = d[0];
      cpps_pkg::CFG_COUNT:         m_count = d[8:0];
      cpps_pkg::CFG_GRAVITY:       m_gacc = d;
      cpps_pkg::CFG_RADIUS:        m_rad = d[30:0];
      cpps_pkg::CFG_WIDTH:         m_wid = d[30:0];
      cpps_pkg::CFG_HEIGHT:        m_hgt = d[30:0];
      default: ;
    endcase
  endtask

  // driver
  item_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_item(cur);
      if (cfg_valid && cfg_ready) begin
        apply_cfg(cfg_index, cfg_data);
        cfg_valid <= 1'b0;
        cfg_req = 0;
      end else if (cfg_req && !cfg_valid) begin
        cfg_valid <= 1'b1;
        cfg_index <= cfg_req_idx;
        cfg_data <= cfg_req_data;
      end
      if (!(start && busy)) begin
        if (pending_items.size() != 0 && !cfg_req &&
            (hold_dense > 0 || $urandom_range(99) >= 25)) begin
          cur = pending_items.pop_front();
          start <= 1'b1;
          in_func <= cur.func;
          in_index <= cur.index;
          in_pos_x <= cur.px;
          in_pos_y <= cur.py;
          in_vel_x <= cur.vx;
          in_vel_y <= cur.vy;
          in_fixed <= cur.fixed;
          in_time_step <= cur.dt;
        end else begin
          start <= 1'b0;
        end
      end
      if (hold_dense > 0) hold_dense <= hold_dense - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    pview_t e;
    if (rst_n && out_valid) begin
      if (read_results.size() == 0) begin
        $display("%0t: unexpected result px=%h", $time, out_pos_x);
        errors++;
      end else begin
        e = read_results.pop_front();
        if (out_pos_x !== e.px) begin
          $display("%0t: pos_x exp %h got %h", $time, e.px, out_pos_x);
          errors++;
        end
        if (out_pos_y !== e.py) begin
          $display("%0t: pos_y exp %h got %h", $time, e.py, out_pos_y);
          errors++;
        end
        if (out_vel_x !== e.vx) begin
          $display("%0t: vel_x exp %h got %h", $time, e.vx, out_vel_x);
          errors++;
        end
        if (out_vel_y !== e.vy) begin
          $display("%0t: vel_y exp %h got %h", $time, e.vy, out_vel_y);
          errors++;
        end
        if (out_fixed !== e.fixed) begin
          $display("%0t: fixed exp %b got %b", $time, e.fixed, out_fixed);
          errors++;
        end
      end
    end
  end

  function automatic item_t mk(input cpps_pkg::func_t f, input logic [7:0] idx,
                               input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] vx, input logic [31:0] vy,
                               input logic fx, input logic [15:0] dt);
    item_t it;
    it.func = f; it.index = idx; it.px = px; it.py = py;
    it.vx = vx; it.vy = vy; it.fixed = fx; it.dt = dt;
    return it;
  endfunction

  task automatic wr_particle(input logic [7:0] idx, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] vx,
                             input logic [31:0] vy, input logic fx);
    pending_items.push_back(mk(cpps_pkg::FN_WRITE, idx, px, py, vx, vy, fx,
                               16'($urandom)));
  endtask

  task automatic rd_particle(input logic [7:0] idx);
    pending_items.push_back(mk(cpps_pkg::FN_READ, idx, $urandom, $urandom, $urandom,
                               $urandom, 1'($urandom), 16'($urandom)));
  endtask

  task automatic settle;
    while (pending_items.size() != 0 || start || busy || read_results.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(input cpps_pkg::cfg_idx_t idx, input logic [31:0] d);
    settle();
    cfg_req_idx = idx;
    cfg_req_data = d;
    cfg_req = 1;
    while (cfg_req) @(posedge clk);
    @(posedge clk);
  endtask

  // random particle mostly inside a 1280x720 box, some outside it, near edges or overlapping
  task automatic rand_particle(input logic [7:0] idx);
    logic [31:0] px, py;
    px = $urandom_range(32'd83886080);
    py = $urandom_range(32'd47185920);
    if ($urandom_range(9) == 0) px = $urandom;
    if ($urandom_range(9) == 0) py = $urandom;
    wr_particle(idx, px, py, $signed($urandom_range(32'h00C80000)) - 32'sh00640000,
                $signed($urandom_range(32'h00C80000)) - 32'sh00640000,
                $urandom_range(5) == 0);
  endtask

  task automatic fill_block(input int n);
    for (int i = 0; i < n; i++) rand_particle(i[7:0]);
  endtask

  task automatic stepn(input logic [15:0] dt);
    pending_items.push_back(mk(cpps_pkg::FN_STEP, 8'($urandom), $urandom, $urandom,
                               $urandom, $urandom, 1'($urandom), dt));
  endtask

  initial begin
    int n;
    m_grav = cpps_pkg::RST_EN_GRAVITY; m_coll = cpps_pkg::RST_EN_COLLISIONS;
    m_walls = cpps_pkg::RST_EN_WALLS; m_count = cpps_pkg::RST_COUNT;
    m_gacc = cpps_pkg::RST_GRAVITY; m_rad = cpps_pkg::RST_RADIUS;
    m_wid = cpps_pkg::RST_WIDTH; m_hgt = cpps_pkg::RST_HEIGHT;
    for (int i = 0; i < NP; i++) begin
      s_px[i] = 0; s_py[i] = 0; s_vx[i] = 0; s_vy[i] = 0; s_fx[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every func, fixed, walls under reset config
    wr_particle(8'd0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
    wr_particle(8'd255, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1);
    wr_particle(8'd1, 32'h00010000, 32'h00010000, 32'hFFF00000, 32'h00100000, 1'b0);
    wr_particle(8'd2, 32'h00100000, 32'h00100000, 32'h00100000, 32'hFFF00000, 1'b1);
    rd_particle(8'd0);
    rd_particle(8'd255);
    pending_items.push_back(mk(cpps_pkg::FN_NONE, 8'd0, '1, '1, '1, '1, 1'b1, '1));
    stepn(16'hFFFF);
    rd_particle(8'd0);
    set_reg(cpps_pkg::CFG_COUNT, 32'd3);
    stepn(16'hFFFF);
    stepn(16'd0);
    rd_particle(8'd0);
    rd_particle(8'd1);
    rd_particle(8'd2);
    set_reg(cpps_pkg::CFG_EN_GRAVITY, 32'd1);
    set_reg(cpps_pkg::CFG_GRAVITY, 32'h80000000);
    stepn(16'h8000);
    rd_particle(8'd0);
    rd_particle(8'd1);
    set_reg(cpps_pkg::CFG_GRAVITY, 32'h7FFFFFFF);
    stepn(16'h0001);
    rd_particle(8'd1);
    // narrow box: both horizontal clamps
    set_reg(cpps_pkg::CFG_WIDTH, 32'h00040000);
    set_reg(cpps_pkg::CFG_HEIGHT, 32'd0);
    stepn(16'h1000);
    rd_particle(8'd0);
    rd_particle(8'd1);
    set_reg(cpps_pkg::CFG_WIDTH, 32'h7FFFFFFF);
    set_reg(cpps_pkg::CFG_HEIGHT, 32'h7FFFFFFF);
    set_reg(cpps_pkg::CFG_RADIUS, 32'hFFFFFFFF);
    stepn(16'h0100);
    rd_particle(8'd1);
    // overlap: coincident pair and a touching pair
    set_reg(cpps_pkg::CFG_RADIUS, 32'h00050000);
    set_reg(cpps_pkg::CFG_EN_COLLISIONS, 32'd1);
    set_reg(cpps_pkg::CFG_EN_GRAVITY, 32'd0);
    wr_particle(8'd0, 32'h00640000, 32'h00640000, 0, 0, 1'b0);
    wr_particle(8'd1, 32'h00640000, 32'h00640000, 0, 0, 1'b0);
    wr_particle(8'd2, 32'h00670000, 32'h00660000, 0, 0, 1'b0);
    stepn(16'h0000);
    rd_particle(8'd0);
    rd_particle(8'd1);
    rd_particle(8'd2);

    // random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      set_reg(cpps_pkg::CFG_EN_GRAVITY, $urandom_range(1));
      set_reg(cpps_pkg::CFG_EN_COLLISIONS, $urandom_range(1));
      set_reg(cpps_pkg::CFG_EN_WALLS, ph == 7 ? 0 : $urandom_range(1));
      set_reg(cpps_pkg::CFG_GRAVITY, ph == 3 ? $urandom : $urandom_range(32'h07000000));
      set_reg(cpps_pkg::CFG_RADIUS, ph == 5 ? 32'h7FFFFFFF : $urandom_range(32'h00200000));
      set_reg(cpps_pkg::CFG_WIDTH, ph == 6 ? 32'd0 : 32'd83886080);
      set_reg(cpps_pkg::CFG_HEIGHT, ph == 6 ? 32'h7FFFFFFF : 32'd47185920);
      n = (ph == 4) ? 6 : $urandom_range(2, 3);
      fill_block(n);
      set_reg(cpps_pkg::CFG_COUNT, n);
      if (ph == 2) hold_dense = 300;
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(3))
          0: rand_particle(8'($urandom_range(n - 1)));
          1: stepn(16'($urandom_range(3) == 0 ? $urandom : $urandom_range(16'h0800)));
          default: rd_particle(8'($urandom_range(n - 1)));
        endcase
        if ($urandom_range(7) == 0) pending_items.push_back(
          mk(cpps_pkg::FN_NONE, 8'($urandom), $urandom, $urandom, $urandom, $urandom,
             1'($urandom), 16'($urandom)));
      end
      for (int k = 0; k < n; k++) rd_particle(k[7:0]);
    end
    settle();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    repeat (50) @(posedge clk);
    if (errors == 0 && read_results.size() == 0) begin
      $display("circle_particle_physics_step_top_tb: done, clean");
    end else begin
      $display("circle_particle_physics_step_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("circle_particle_physics_step_top_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

// ===== circle_particle_physics_step_top.f =====
design/cpps_pkg.sv
design/cpps_ctrl.sv
design/cpps_dp.sv
design/circle_particle_physics_step_top.sv
verif/circle_particle_physics_step_top_tb.sv
